// File: hdl/pot_pkg.sv
// ---------------------------------------------------------------------------
// pot_pkg
// Shared types and constants of the perturb-and-observe phase tracker.
// ---------------------------------------------------------------------------
package pot_pkg;

  localparam int unsigned SampleBits    = 12;
  localparam int unsigned PhaseFracBits = 8;
  localparam int unsigned MaxWindowDef  = 1023;

  localparam int unsigned CfgW      = 24;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned SpuW      = 10;
  localparam int unsigned StepW     = 16;
  localparam int unsigned PhaseW    = 24;
  localparam int unsigned BaseW     = 23;
  localparam int unsigned FineW     = 8;
  localparam int unsigned CoarseW   = 16;
  localparam int unsigned PhaseExtW = 26;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 48;
  localparam int unsigned OutUserW  = 4;

  localparam logic [SpuW-1:0]   SpuRst   = SpuW'(50);
  localparam logic [StepW-1:0]  StepRst  = StepW'(256);
  localparam logic [PhaseW-1:0] LowRst   = PhaseW'(0);
  localparam logic [PhaseW-1:0] HighRst  = PhaseW'(51200);
  localparam logic [BaseW-1:0]  BaseRst  = BaseW'(51200);
  localparam logic [FineW-1:0]  FineRst  = FineW'(60);

  typedef enum logic [CfgAddrW-1:0] {
    REG_SPU   = 3'd0,
    REG_STEP  = 3'd1,
    REG_LOW   = 3'd2,
    REG_HIGH  = 3'd3,
    REG_BASE  = 3'd4,
    REG_FINE  = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_V,
    ST_ACC_I,
    ST_MUL,
    ST_CMP_P,
    ST_CMP_I,
    ST_CMP_V,
    ST_STEP,
    ST_CHK_HI,
    ST_CHK_LO,
    ST_DIFF,
    ST_FINE,
    ST_COARSE,
    ST_DONE
  } step_e;

  typedef struct packed {
    step_e step;
    logic  s_ready;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic window_done;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/pot_alu.sv
// ---------------------------------------------------------------------------
// pot_alu
// Shared add/subtract unit with signed less/greater flags.
// ---------------------------------------------------------------------------
module pot_alu #(
  parameter int unsigned Width = 45
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  input  logic             sub_i,
  output logic [Width-1:0] res_o,
  output logic             lt_o,
  output logic             gt_o
);

  assign res_o = a_i + (sub_i ? ~b_i : b_i) + Width'(sub_i);
  assign lt_o  = res_o[Width-1];
  assign gt_o  = !res_o[Width-1] && (|res_o);

endmodule

// File: hdl/pot_ctrl.sv
// ---------------------------------------------------------------------------
// pot_ctrl
// Sequencer stepping the shared unit through accumulate and tracking steps.
// ---------------------------------------------------------------------------
module pot_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pot_pkg::stat_t stat_i,
  output pot_pkg::ctrl_t ctrl_o
);

  import pot_pkg::*;

  step_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    ctrl_o.step    = state_q;
    ctrl_o.s_ready = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE:   if (stat_i.in_valid) state_d = ST_ACC_V;
      ST_ACC_V:  state_d = ST_ACC_I;
      ST_ACC_I:  state_d = stat_i.window_done ? ST_MUL : ST_IDLE;
      ST_MUL:    state_d = ST_CMP_P;
      ST_CMP_P:  state_d = ST_CMP_I;
      ST_CMP_I:  state_d = ST_CMP_V;
      ST_CMP_V:  state_d = ST_STEP;
      ST_STEP:   state_d = ST_CHK_HI;
      ST_CHK_HI: state_d = ST_CHK_LO;
      ST_CHK_LO: state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_FINE;
      ST_FINE:   state_d = ST_COARSE;
      ST_COARSE: state_d = ST_DONE;
      ST_DONE:   if (stat_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/perturb_observe_phase_tracker.sv
// ---------------------------------------------------------------------------
// perturb_observe_phase_tracker
// Window power tracking with perturb-and-observe phase stepping.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake               | payload
//  s_axis   | in  | tvalid/tready           | tdata: voltage, current samples
//  m_axis   | out | tvalid/tready           | tdata: shift word, phase; tuser: flags
//  cfg      | in  | cfg_we_i, no back-press | cfg_addr_i, cfg_wdata_i
//
// A sample pair passes accept, voltage add and current add in turn through
// the single shared adder. A window-closing pair then adds a multiply,
// then compares, phase step, wrap checks and word build on the same adder.
// Reset restores register defaults and clears sums, phase and history.
// A full output register stalls the last step until the item is taken.
// ---------------------------------------------------------------------------
module perturb_observe_phase_tracker #(
  parameter int unsigned MaxWindow = pot_pkg::MaxWindowDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [11:0] voltage_sample, [23:12] current_sample
  input  logic [pot_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [23:0] shift_word, [47:24] phase_position
  output logic [pot_pkg::OutDataW-1:0]  m_axis_tdata,
  // [0] power_rose, [1] current_rose, [2] voltage_rose, [3] moving_up
  output logic [pot_pkg::OutUserW-1:0]  m_axis_tuser,
  input  logic                          cfg_we_i,
  input  logic [pot_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [pot_pkg::CfgW-1:0]      cfg_wdata_i
);

  import pot_pkg::*;

  localparam int unsigned CntW = (MaxWindow > 1) ? $clog2(MaxWindow + 1) : 1;
  localparam int unsigned SumW = SampleBits + CntW;
  localparam int unsigned PowW = 2 * SumW;
  localparam int unsigned AluW = ((PowW > PhaseExtW) ? PowW : PhaseExtW) + 1;
  localparam int unsigned CmpW = ((CntW > SpuW) ? CntW : SpuW) + 1;

  // configuration
  logic [SpuW-1:0]          spu_q;
  logic [StepW-1:0]         step_q;
  logic signed [PhaseW-1:0] low_q, high_q;
  logic [BaseW-1:0]         base_q;
  logic [FineW-1:0]         fsteps_q;

  // state
  logic [SampleBits-1:0]    vin_q, iin_q;
  logic [SumW-1:0]          vsum_q, isum_q, last_v_q, last_i_q;
  logic [CntW-1:0]          cnt_q;
  logic [PowW-1:0]          power_q, last_power_q;
  logic signed [PhaseW-1:0] phase_q;
  logic                     dir_q, prose_q, pfell_q, irose_q, vrose_q, hiw_q;
  logic signed [PhaseExtW-1:0] p_q, v_q;
  logic [FineW-1:0]         fine_q, fine_out_q;
  logic [CoarseW-1:0]       coarse_q;
  logic                     out_valid_q;
  logic [OutDataW-1:0]      out_data_q;
  logic [OutUserW-1:0]      out_user_q;

  ctrl_t ctrl;
  stat_t stat;

  logic [AluW-1:0] alu_a, alu_b, alu_res;
  logic            alu_sub, alu_lt, alu_gt;
  logic            dir_new, moved;
  logic [CmpW-1:0] cnt_inc, len_eff;
  logic [PhaseFracBits+FineW-1:0] fine_prod;

  always_comb begin
    if (spu_q == '0) begin
      len_eff = CmpW'(1);
    end else if (CmpW'(spu_q) > CmpW'(MaxWindow)) begin
      len_eff = CmpW'(MaxWindow);
    end else begin
      len_eff = CmpW'(spu_q);
    end
  end

  assign cnt_inc = CmpW'(cnt_q) + CmpW'(1);

  assign stat.in_valid    = s_axis_tvalid;
  assign stat.window_done = (cnt_inc >= len_eff);
  assign stat.out_free    = !out_valid_q || m_axis_tready;

  pot_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign dir_new = pfell_q ? !dir_q : dir_q;
  assign moved   = prose_q || pfell_q;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (ctrl.step)
      ST_ACC_V: begin
        alu_a = AluW'(vsum_q);
        alu_b = AluW'(vin_q);
      end
      ST_ACC_I: begin
        alu_a = AluW'(isum_q);
        alu_b = AluW'(iin_q);
      end
      ST_CMP_P: begin
        alu_a   = AluW'(power_q);
        alu_b   = AluW'(last_power_q);
        alu_sub = 1'b1;
      end
      ST_CMP_I: begin
        alu_a   = AluW'(isum_q);
        alu_b   = AluW'(last_i_q);
        alu_sub = 1'b1;
      end
      ST_CMP_V: begin
        alu_a   = AluW'(vsum_q);
        alu_b   = AluW'(last_v_q);
        alu_sub = 1'b1;
      end
      ST_STEP: begin
        alu_a   = AluW'(phase_q);
        alu_b   = moved ? AluW'(step_q) : '0;
        alu_sub = moved && !dir_new;
      end
      ST_CHK_HI: begin
        alu_a   = AluW'(p_q);
        alu_b   = AluW'(high_q);
        alu_sub = 1'b1;
      end
      ST_CHK_LO: begin
        alu_a   = AluW'(p_q);
        alu_b   = AluW'(low_q);
        alu_sub = 1'b1;
      end
      ST_DIFF: begin
        alu_a   = AluW'(base_q);
        alu_b   = AluW'(phase_q);
        alu_sub = 1'b1;
      end
      ST_COARSE: begin
        alu_a = AluW'(v_q >>> PhaseFracBits);
        alu_b = AluW'(fine_q != '0);
      end
      default: ;
    endcase
  end

  pot_alu #(
    .Width (AluW)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .lt_o  (alu_lt),
    .gt_o  (alu_gt)
  );

  assign fine_prod = (PhaseFracBits+FineW)'(v_q[PhaseFracBits-1:0])
                   * (PhaseFracBits+FineW)'(fsteps_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spu_q    <= SpuRst;
      step_q   <= StepRst;
      low_q    <= LowRst;
      high_q   <= HighRst;
      base_q   <= BaseRst;
      fsteps_q <= FineRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_SPU:  spu_q    <= cfg_wdata_i[SpuW-1:0];
        REG_STEP: step_q   <= cfg_wdata_i[StepW-1:0];
        REG_LOW:  low_q    <= cfg_wdata_i[PhaseW-1:0];
        REG_HIGH: high_q   <= cfg_wdata_i[PhaseW-1:0];
        REG_BASE: base_q   <= cfg_wdata_i[BaseW-1:0];
        REG_FINE: fsteps_q <= cfg_wdata_i[FineW-1:0];
        default: ;
      endcase
    end
  end

  // tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsum_q       <= '0;
      isum_q       <= '0;
      cnt_q        <= '0;
      last_v_q     <= '0;
      last_i_q     <= '0;
      last_power_q <= '0;
      phase_q      <= '0;
      dir_q        <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      if ((ctrl.step == ST_DONE) && stat.out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (ctrl.step)
        ST_ACC_V: vsum_q <= alu_res[SumW-1:0];
        ST_ACC_I: begin
          isum_q <= alu_res[SumW-1:0];
          cnt_q  <= stat.window_done ? '0 : cnt_inc[CntW-1:0];
        end
        ST_STEP:  dir_q <= dir_new;
        ST_CHK_LO: phase_q <= (!hiw_q && alu_lt) ? high_q : p_q[PhaseW-1:0];
        ST_DONE: begin
          if (stat.out_free) begin
            last_v_q     <= vsum_q;
            last_i_q     <= isum_q;
            last_power_q <= power_q;
            vsum_q       <= '0;
            isum_q       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and step results
  always_ff @(posedge clk_i) begin
    if (ctrl.s_ready && s_axis_tvalid) begin
      vin_q <= s_axis_tdata[SampleBits-1:0];
      iin_q <= s_axis_tdata[2*SampleBits-1:SampleBits];
    end
    case (ctrl.step)
      ST_MUL:   power_q <= PowW'(vsum_q) * PowW'(isum_q);
      ST_CMP_P: begin
        prose_q <= alu_gt;
        pfell_q <= alu_lt;
      end
      ST_CMP_I: irose_q <= alu_gt;
      ST_CMP_V: vrose_q <= alu_gt;
      ST_STEP:  p_q <= alu_res[PhaseExtW-1:0];
      ST_CHK_HI: begin
        hiw_q <= alu_gt;
        if (alu_gt) p_q <= PhaseExtW'(low_q);
      end
      ST_DIFF:  v_q <= alu_res[PhaseExtW-1:0];
      ST_FINE:  fine_q <= fine_prod[PhaseFracBits +: FineW];
      ST_COARSE: begin
        coarse_q   <= alu_res[CoarseW-1:0];
        fine_out_q <= (fine_q != '0) ? (fsteps_q - fine_q) : '0;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          out_data_q <= {phase_q, coarse_q, fine_out_q};
          out_user_q <= {dir_q, vrose_q, irose_q, prose_q};
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = ctrl.s_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// File: sim/phase_tracker_sb_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// phase_tracker_sb_pkg
// Predicts the tracking step of each closed sample window and checks the
// results of the phase tracker against it, field by field, in order.
// ---------------------------------------------------------------------------
package phase_tracker_sb_pkg;
  import pot_pkg::*;

  typedef struct packed {
    logic [23:0] shift_word;
    logic [23:0] phase_position;
    logic        power_rose;
    logic        current_rose;
    logic        voltage_rose;
    logic        moving_up;
  } tracker_result_t;

  class phase_tracker_sb;
    // register copies
    logic [SpuW-1:0]          win_len;
    logic [StepW-1:0]         step_q8;
    logic signed [PhaseW-1:0] low_q8;
    logic signed [PhaseW-1:0] high_q8;
    logic [BaseW-1:0]         base_q8;
    logic [FineW-1:0]         fine_per_coarse;
    // tracker state
    longint unsigned          v_sum;
    longint unsigned          i_sum;
    longint unsigned          prev_v_sum;
    longint unsigned          prev_i_sum;
    longint unsigned          prev_power;
    int unsigned              pairs_seen;
    logic signed [PhaseW-1:0] phase_q8;
    bit                       dir_up;

    tracker_result_t          expected_q[$];
    int unsigned              errors;
    int unsigned              results_seen;

    function new();
      win_len         = SpuRst;
      step_q8         = StepRst;
      low_q8          = LowRst;
      high_q8         = HighRst;
      base_q8         = BaseRst;
      fine_per_coarse = FineRst;
      v_sum           = 0;
      i_sum           = 0;
      prev_v_sum      = 0;
      prev_i_sum      = 0;
      prev_power      = 0;
      pairs_seen      = 0;
      phase_q8        = '0;
      dir_up          = 1'b1;
      errors          = 0;
      results_seen    = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CfgW-1:0] value);
      case (idx)
        REG_SPU:  win_len = value[SpuW-1:0];
        REG_STEP: step_q8 = value[StepW-1:0];
        REG_LOW:  low_q8 = value[PhaseW-1:0];
        REG_HIGH: high_q8 = value[PhaseW-1:0];
        REG_BASE: base_q8 = value[BaseW-1:0];
        REG_FINE: fine_per_coarse = value[FineW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Accumulate one accepted sample pair; a closing pair yields a result.
    function void note_pair(logic [SampleBits-1:0] volt, logic [SampleBits-1:0] curr);
      int unsigned     len;
      longint unsigned pwr;
      longint          p;
      longint          diff;
      longint          coarse;
      longint unsigned frac;
      longint unsigned fine_cnt;
      tracker_result_t r;
      len = win_len;
      if (len == 0) len = 1;
      if (len > MaxWindowDef) len = MaxWindowDef;
      v_sum += volt;
      i_sum += curr;
      pairs_seen++;
      if (pairs_seen < len) return;

      pwr = v_sum * i_sum;
      r.power_rose   = pwr > prev_power;
      r.current_rose = i_sum > prev_i_sum;
      r.voltage_rose = v_sum > prev_v_sum;

      p = longint'(phase_q8);
      if (pwr > prev_power) begin
        p += dir_up ? longint'(step_q8) : -longint'(step_q8);
      end else if (pwr < prev_power) begin
        dir_up = !dir_up;
        p += dir_up ? longint'(step_q8) : -longint'(step_q8);
      end
      if (p > longint'(high_q8)) p = longint'(low_q8);
      else if (p < longint'(low_q8)) p = longint'(high_q8);
      phase_q8 = p[PhaseW-1:0];

      // phase word: base minus phase, rounded up, fine part complemented
      diff     = longint'(base_q8) - p;
      frac     = diff & 64'hFF;
      coarse   = diff >>> PhaseFracBits;
      fine_cnt = (frac * fine_per_coarse) >> PhaseFracBits;
      if (fine_cnt != 0) begin
        coarse   = coarse + 1;
        fine_cnt = fine_per_coarse - fine_cnt;
      end
      r.shift_word     = {coarse[CoarseW-1:0], fine_cnt[7:0]};
      r.phase_position = phase_q8;
      r.moving_up      = dir_up;
      expected_q.push_back(r);

      prev_v_sum = v_sum;
      prev_i_sum = i_sum;
      prev_power = pwr;
      v_sum      = 0;
      i_sum      = 0;
      pairs_seen = 0;
    endfunction

    task report_mismatch(string field, longint got, longint want);
      $display("%0t MISMATCH %s in result %0d: got 0x%0h, expected 0x%0h",
               $time, field, results_seen, got, want);
      errors++;
    endtask

    task check_result(logic [OutDataW-1:0] data, logic [OutUserW-1:0] user);
      tracker_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", data, 0);
        return;
      end
      want = expected_q.pop_front();
      if (data[23:0] !== want.shift_word)
        report_mismatch("shift_word", data[23:0], want.shift_word);
      if (data[47:24] !== want.phase_position)
        report_mismatch("phase_position", data[47:24], want.phase_position);
      if (user[0] !== want.power_rose)
        report_mismatch("power_rose", user[0], want.power_rose);
      if (user[1] !== want.current_rose)
        report_mismatch("current_rose", user[1], want.current_rose);
      if (user[2] !== want.voltage_rose)
        report_mismatch("voltage_rose", user[2], want.voltage_rose);
      if (user[3] !== want.moving_up)
        report_mismatch("moving_up", user[3], want.moving_up);
    endtask
  endclass

endpackage

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives sample pairs into the phase tracker under several register settings
// and idle patterns, and checks every tracking result against a prediction.
// ---------------------------------------------------------------------------
module testbench;
  import pot_pkg::*;
  import phase_tracker_sb_pkg::*;

  localparam int unsigned SettleCycles  = 32;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned PhaseItems    = 62;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [OutUserW-1:0]  m_axis_tuser;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr_i    = '0;
  logic [CfgW-1:0]      cfg_wdata_i   = '0;

  int unsigned          idle_pct      = 0;
  int unsigned          stall_pct     = 0;
  int unsigned          quiet_cycles  = 0;

  phase_tracker_sb      sb = new();

  always #1 clk_i = ~clk_i;

  perturb_observe_phase_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // monitors and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_pair(s_axis_tdata[11:0], s_axis_tdata[23:12]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t watchdog: no item moved in %0d cycles", $time, quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task send_pair(input logic [SampleBits-1:0] volt, input logic [SampleBits-1:0] curr);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {curr, volt};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // wait until every result is in and the block has gone quiet
  task settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task write_reg(input reg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  task apply_config(input logic [SpuW-1:0] spu, input logic [StepW-1:0] stp,
                    input logic [PhaseW-1:0] lo, input logic [PhaseW-1:0] hi,
                    input logic [BaseW-1:0] base, input logic [FineW-1:0] fine);
    write_reg(REG_SPU, CfgW'(spu));
    write_reg(REG_STEP, CfgW'(stp));
    write_reg(REG_LOW, lo);
    write_reg(REG_HIGH, hi);
    write_reg(REG_BASE, CfgW'(base));
    write_reg(REG_FINE, CfgW'(fine));
    cfg_we_i <= 1'b0;
  endtask

  task random_config();
    logic [SpuW-1:0]          spu;
    logic [StepW-1:0]         stp;
    logic signed [PhaseW-1:0] lo;
    logic signed [PhaseW-1:0] hi;
    logic [BaseW-1:0]         base;
    int                       k;
    case ($urandom_range(0, 9))
      0: spu = '0;
      1: spu = SpuW'($urandom_range(7, 40));
      default: spu = SpuW'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 3))
      0: stp = 16'd1;
      1: stp = 16'hFFFF;
      default: stp = StepW'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 3))
      0: begin
        k  = $urandom_range(0, 4000);
        lo = PhaseW'(-k);
        hi = PhaseW'(k);
      end
      1: begin
        lo = PhaseW'($urandom);
        hi = PhaseW'($urandom);
      end
      2: begin
        lo = 24'sh800000;
        hi = 24'sh7FFFFF;
      end
      default: begin
        lo = PhaseW'($urandom_range(0, 2000));
        hi = lo + PhaseW'($urandom_range(0, 60000));
      end
    endcase
    case ($urandom_range(0, 3))
      0: base = '0;
      1: base = 23'h7FFFFF;
      default: base = BaseW'($urandom);
    endcase
    apply_config(spu, stp, lo, hi, base, FineW'($urandom_range(0, 255)));
  endtask

  function automatic logic [SampleBits-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return SampleBits'($urandom);
    endcase
  endfunction

  task random_items(input int unsigned count);
    logic [SampleBits-1:0] volt;
    logic [SampleBits-1:0] curr;
    volt = pick_sample();
    curr = pick_sample();
    for (int n = 0; n < count; n++) begin
      // repeated pairs make equal window power likely
      if ($urandom_range(0, 9) != 0) begin
        volt = pick_sample();
        curr = pick_sample();
      end
      send_pair(volt, curr);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-pair windows: equal power at zero, rise, hold, fall
    apply_config(10'd1, 16'd256, 24'd0, 24'd51200, 23'd51200, 8'd60);
    send_pair(12'd0, 12'd0);
    send_pair(12'hFFF, 12'hFFF);
    send_pair(12'hFFF, 12'hFFF);
    send_pair(12'd0, 12'hFFF);
    send_pair(12'hFFF, 12'd0);
    send_pair(12'd1, 12'd1);
    settle();

    // widest limits and step, phase above base
    apply_config(10'd1, 16'hFFFF, 24'h800000, 24'h7FFFFF, 23'd0, 8'd255);
    send_pair(12'd100, 12'd100);
    send_pair(12'd200, 12'd200);
    send_pair(12'd50, 12'd50);
    send_pair(12'hFFF, 12'hFFF);
    settle();

    // zero window length, crossed limits, no fine steps
    apply_config(10'd0, 16'd1, 24'h7FFFFF, 24'h800000, 23'h7FFFFF, 8'd0);
    send_pair(12'd7, 12'd9);
    send_pair(12'd3, 12'd2);
    send_pair(12'hABC, 12'h543);
    settle();

    // longest window shortened while partly filled
    apply_config(10'd1023, 16'd256, -24'sd100, 24'sd100, 23'd51200, 8'd1);
    for (int n = 0; n < 5; n++) send_pair(pick_sample(), pick_sample());
    settle();
    write_reg(REG_SPU, CfgW'(3));
    cfg_we_i <= 1'b0;
    send_pair(12'h800, 12'h7FF);
    settle();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      random_config();
      random_items(PhaseItems);
      settle();
    end

    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: perturb_observe_phase_tracker.f
hdl/pot_pkg.sv
hdl/pot_alu.sv
hdl/pot_ctrl.sv
hdl/perturb_observe_phase_tracker.sv
sim/phase_tracker_sb_pkg.sv
sim/testbench.sv
